// ===== hw/rtl/layer_z_order_stack_hit_test_defines.svh =====
// Assertion macros for the checker file.
`ifndef LAYER_Z_ORDER_STACK_HIT_TEST_DEFINES_SVH
`define LAYER_Z_ORDER_STACK_HIT_TEST_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LZST_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("lzst assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LZST_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lzst assertion failed");

`endif

// ===== hw/rtl/lzst_pkg.sv =====
package lzst_pkg;

    localparam int MAX_LAYERS = 16;
    localparam int ID_W       = 5;
    localparam int IDX_W      = $clog2(MAX_LAYERS);
    localparam int CNT_W      = $clog2(MAX_LAYERS + 1);
    localparam int OP_W       = 3;
    localparam int STAT_W     = 2;
    localparam int TH_W       = 8;

    localparam logic [OP_W-1:0] OP_NEW     = 3'd0;
    localparam logic [OP_W-1:0] OP_WINDOW  = 3'd1;
    localparam logic [OP_W-1:0] OP_MOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_MOVEREL = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTACK = 3'd4;
    localparam logic [OP_W-1:0] OP_HIDE    = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd2;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rm_step;
        logic ins_start;
        logic ins_step;
        logic q_step;
        logic load_out;
    } lzst_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            known;
        logic            rm_empty;
        logic            rm_last;
        logic            ins_skip;
        logic            ins_done;
        logic            q_hit;
        logic            q_end;
        logic            out_busy;
    } lzst_sts_t;

endpackage

// ===== hw/rtl/lzst_ctrl.sv =====
module lzst_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lzst_pkg::lzst_sts_t sts,
    output lzst_pkg::lzst_cmd_t cmd
);
    import lzst_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RM   = 3'd2;
    localparam logic [2:0] S_INSS = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_QRY  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                priority if ((sts.op == OP_RESTACK || sts.op == OP_HIDE) && sts.known)
                    state_next = S_RM;
                else if (sts.op == OP_FIND)
                    state_next = S_QRY;
                else
                    state_next = S_FIN;
            end
            S_RM:
            begin
                if (sts.rm_empty)
                begin
                    state_next = S_INSS;
                end
                else
                begin
                    cmd.rm_step = 1'b1;
                    if (sts.rm_last)
                        state_next = S_INSS;
                end
            end
            S_INSS:
            begin
                if (sts.ins_skip)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.ins_start = 1'b1;
                    state_next    = S_INS;
                end
            end
            S_INS:
            begin
                cmd.ins_step = 1'b1;
                if (sts.ins_done)
                    state_next = S_FIN;
            end
            S_QRY:
            begin
                cmd.q_step = 1'b1;
                if (sts.q_hit || sts.q_end)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lzst_datapath.sv =====
module lzst_datapath #(
    parameter int COORD_WIDTH = 16,
    parameter int SIZE_WIDTH  = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lzst_pkg::lzst_cmd_t                cmd,
    output lzst_pkg::lzst_sts_t                sts,
    input  logic [lzst_pkg::OP_W-1:0]          op,
    input  logic [lzst_pkg::ID_W-1:0]          layer_id,
    input  logic signed [COORD_WIDTH-1:0]      coord_x,
    input  logic signed [COORD_WIDTH-1:0]      coord_y,
    input  logic [SIZE_WIDTH-1:0]              win_width,
    input  logic [SIZE_WIDTH-1:0]              win_height,
    input  logic signed [lzst_pkg::TH_W-1:0]   target_height,
    input  logic [lzst_pkg::ID_W-1:0]          skip_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lzst_pkg::ID_W-1:0]          result_id,
    output logic                               hit,
    output logic [lzst_pkg::STAT_W-1:0]        status,
    output logic [lzst_pkg::ID_W-1:0]          shown_count
);
    import lzst_pkg::*;

    localparam int EW = ((COORD_WIDTH > SIZE_WIDTH) ? COORD_WIDTH : SIZE_WIDTH) + 2;

    // captured item
    logic [OP_W-1:0]         op_reg;
    logic [ID_W-1:0]         id_reg, excl_reg;
    logic [COORD_WIDTH-1:0]  cx_reg, cy_reg;
    logic [SIZE_WIDTH-1:0]   ww_reg, wh_reg;
    logic [TH_W-1:0]         th_reg;

    // layer table and stack
    logic [COORD_WIDTH-1:0]  tbl_x [MAX_LAYERS];
    logic [COORD_WIDTH-1:0]  tbl_y [MAX_LAYERS];
    logic [SIZE_WIDTH-1:0]   tbl_w [MAX_LAYERS];
    logic [SIZE_WIDTH-1:0]   tbl_h [MAX_LAYERS];
    logic [MAX_LAYERS-1:0]   has_win_reg;
    logic [ID_W-1:0]         stk [MAX_LAYERS];

    logic [CNT_W-1:0]        count_reg, last_reg, i_reg, h_reg;
    logic                    found_reg, sid_vld_reg, out_valid_reg;
    logic [ID_W-1:0]         sid_reg;
    logic [ID_W-1:0]         rid_reg, out_id_reg, out_cnt_reg;
    logic                    hit_reg, out_hit_reg;
    logic [STAT_W-1:0]       stat_reg, out_stat_reg;

    logic                    known, full;
    logic [IDX_W-1:0]        k_idx, new_idx, sid_idx, tbl_idx, stk_rd_idx, im1_idx;
    logic [ID_W-1:0]         stk_rd;
    logic [COORD_WIDTH-1:0]  rd_x, rd_y;
    logic [SIZE_WIDTH-1:0]   rd_w, rd_h;
    logic signed [EW-1:0]    px_e, py_e, x0_e, y0_e, x1_e, y1_e;
    logic                    in_box, q_match;
    logic [TH_W-1:0]         cnt_th;
    logic [STAT_W-1:0]       exec_stat;

    function automatic logic layer_id_known(input logic [ID_W-1:0] id);
        layer_id_known = (id != '0) && (id <= ID_W'(last_reg));
    endfunction

    assign known   = (layer_id_known(id_reg));
    assign full    = (last_reg == CNT_W'(MAX_LAYERS));
    assign k_idx   = IDX_W'(id_reg - 1'b1);
    assign new_idx = last_reg[IDX_W-1:0];
    assign sid_idx = IDX_W'(sid_reg - 1'b1);
    assign im1_idx = IDX_W'(i_reg - 1'b1);
    assign tbl_idx = cmd.q_step ? sid_idx : k_idx;
    assign stk_rd_idx = cmd.rm_step ? i_reg[IDX_W-1:0] : im1_idx;
    assign stk_rd  = stk[stk_rd_idx];
    assign rd_x    = tbl_x[tbl_idx];
    assign rd_y    = tbl_y[tbl_idx];
    assign rd_w    = tbl_w[tbl_idx];
    assign rd_h    = tbl_h[tbl_idx];

    // containment with inclusive far edges, no wrap on the far edge
    assign px_e   = {{(EW-COORD_WIDTH){cx_reg[COORD_WIDTH-1]}}, cx_reg};
    assign py_e   = {{(EW-COORD_WIDTH){cy_reg[COORD_WIDTH-1]}}, cy_reg};
    assign x0_e   = {{(EW-COORD_WIDTH){rd_x[COORD_WIDTH-1]}}, rd_x};
    assign y0_e   = {{(EW-COORD_WIDTH){rd_y[COORD_WIDTH-1]}}, rd_y};
    assign x1_e   = x0_e + $signed({{(EW-SIZE_WIDTH){1'b0}}, rd_w});
    assign y1_e   = y0_e + $signed({{(EW-SIZE_WIDTH){1'b0}}, rd_h});
    assign in_box = (x0_e <= px_e) && (px_e <= x1_e) && (y0_e <= py_e) && (py_e <= y1_e);
    assign q_match = sid_vld_reg && (sid_reg != excl_reg) && has_win_reg[sid_idx] && in_box;

    assign cnt_th = TH_W'(count_reg);

    always_comb
    begin
        exec_stat = ST_OK;
        if (op_reg == OP_NEW && full)
            exec_stat = ST_NOFREE;
        else if (!known && op_reg >= OP_WINDOW && op_reg <= OP_HIDE)
            exec_stat = ST_UNKNOWN;
    end

    always_comb
    begin
        sts          = '0;
        sts.op       = op_reg;
        sts.known    = known;
        sts.rm_empty = (count_reg == '0);
        sts.rm_last  = (CNT_W'(i_reg + 1'b1) == count_reg);
        sts.ins_skip = (op_reg != OP_RESTACK) || th_reg[TH_W-1]
                       || (count_reg == CNT_W'(MAX_LAYERS));
        sts.ins_done = (i_reg <= h_reg);
        sts.q_hit    = q_match;
        sts.q_end    = !q_match && (i_reg == '0);
        sts.out_busy = out_valid_reg && !out_ready;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= '0;
            i_reg         <= '0;
            found_reg     <= 1'b0;
            sid_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            has_win_reg   <= '0;
        end
        else
        begin
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.exec)
            begin
                unique case (op_reg)
                    OP_NEW:
                    begin
                        if (!full)
                        begin
                            last_reg             <= CNT_W'(last_reg + 1'b1);
                            has_win_reg[new_idx] <= 1'b0;
                        end
                    end
                    OP_WINDOW:
                    begin
                        if (known)
                            has_win_reg[k_idx] <= 1'b1;
                    end
                    OP_RESTACK, OP_HIDE:
                    begin
                        i_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                    OP_FIND:
                    begin
                        i_reg       <= count_reg;
                        sid_vld_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.rm_step)
            begin
                i_reg <= CNT_W'(i_reg + 1'b1);
                if (stk_rd == id_reg)
                    found_reg <= 1'b1;
                if (sts.rm_last && (found_reg || stk_rd == id_reg))
                    count_reg <= CNT_W'(count_reg - 1'b1);
            end
            if (cmd.ins_start)
                i_reg <= count_reg;
            if (cmd.ins_step)
            begin
                if (i_reg > h_reg)
                    i_reg <= CNT_W'(i_reg - 1'b1);
                else
                    count_reg <= CNT_W'(count_reg + 1'b1);
            end
            if (cmd.q_step && !q_match && i_reg != '0)
            begin
                sid_vld_reg <= 1'b1;
                i_reg       <= CNT_W'(i_reg - 1'b1);
            end
        end
    end

    // payload: captured item, results, table, stack
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= op;
            id_reg   <= layer_id;
            cx_reg   <= coord_x;
            cy_reg   <= coord_y;
            ww_reg   <= win_width;
            wh_reg   <= win_height;
            th_reg   <= target_height;
            excl_reg <= skip_id;
        end
        if (cmd.exec)
        begin
            rid_reg  <= (op_reg == OP_NEW && !full) ? ID_W'(last_reg + 1'b1) : '0;
            hit_reg  <= 1'b0;
            stat_reg <= exec_stat;
            unique case (op_reg)
                OP_NEW:
                begin
                    if (!full)
                    begin
                        tbl_x[new_idx] <= '0;
                        tbl_y[new_idx] <= '0;
                        tbl_w[new_idx] <= '0;
                        tbl_h[new_idx] <= '0;
                    end
                end
                OP_WINDOW:
                begin
                    if (known)
                    begin
                        tbl_w[k_idx] <= ww_reg;
                        tbl_h[k_idx] <= wh_reg;
                    end
                end
                OP_MOVE:
                begin
                    if (known)
                    begin
                        tbl_x[k_idx] <= cx_reg;
                        tbl_y[k_idx] <= cy_reg;
                    end
                end
                OP_MOVEREL:
                begin
                    if (known)
                    begin
                        tbl_x[k_idx] <= rd_x + cx_reg;
                        tbl_y[k_idx] <= rd_y + cy_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.rm_step && found_reg)
            stk[im1_idx] <= stk_rd;
        if (cmd.ins_start)
            h_reg <= (th_reg > cnt_th) ? count_reg : CNT_W'(th_reg);
        if (cmd.ins_step)
        begin
            if (i_reg > h_reg)
                stk[i_reg[IDX_W-1:0]] <= stk_rd;
            else
                stk[h_reg[IDX_W-1:0]] <= id_reg;
        end
        if (cmd.q_step)
        begin
            if (q_match)
            begin
                rid_reg <= sid_reg;
                hit_reg <= 1'b1;
            end
            else if (i_reg != '0)
            begin
                sid_reg <= stk_rd;
            end
        end
        if (cmd.load_out)
        begin
            out_id_reg   <= rid_reg;
            out_hit_reg  <= hit_reg;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= ID_W'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_id   = out_id_reg;
    assign hit         = out_hit_reg;
    assign status      = out_stat_reg;
    assign shown_count = out_cnt_reg;

endmodule

// ===== hw/rtl/layer_z_order_stack_hit_test.sv =====
// Window layer z-order manager with point hit test.
// Input channel (in_valid / in_ready): one operation per transfer: new layer,
// set window, move, move relative, restack, hide, find at point.
// Output channel (out_valid / out_ready): exactly one result per operation,
// in order: result_id, hit, status, shown_count.
// Steps per item: capture, execute, then register the result. Table ops (new,
// window, move, move relative) finish after execute. Hide and restack walk the
// stack one entry a cycle to remove the layer, then restack shifts entries one
// a cycle to open the slot. Find walks the stack top down one entry a cycle
// through a one-deep fetch stage. The single stack read port paces the walks.
// One item is in work at a time; in_ready is high only between items.
// The result register parts the channels: a new item is taken while the last
// result waits, and a finished item holds until the receiver takes the slot.
// Reset clears the stack count, the layer count and all window flags; layer
// positions, sizes and stack entries need no clearing since each is written
// before it is read.
module layer_z_order_stack_hit_test #(
    parameter int COORD_WIDTH = 16,
    parameter int SIZE_WIDTH  = 13
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lzst_pkg::OP_W-1:0]          op,
    input  logic [lzst_pkg::ID_W-1:0]          layer_id,
    input  logic signed [COORD_WIDTH-1:0]      coord_x,
    input  logic signed [COORD_WIDTH-1:0]      coord_y,
    input  logic [SIZE_WIDTH-1:0]              win_width,
    input  logic [SIZE_WIDTH-1:0]              win_height,
    input  logic signed [lzst_pkg::TH_W-1:0]   target_height,
    input  logic [lzst_pkg::ID_W-1:0]          skip_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lzst_pkg::ID_W-1:0]          result_id,
    output logic                               hit,
    output logic [lzst_pkg::STAT_W-1:0]        status,
    output logic [lzst_pkg::ID_W-1:0]          shown_count
);
    import lzst_pkg::*;

    lzst_cmd_t cmd;
    lzst_sts_t sts;

    // sequence the operation
    lzst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold layer table, stack and result register
    lzst_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .SIZE_WIDTH  (SIZE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .layer_id      (layer_id),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .win_width     (win_width),
        .win_height    (win_height),
        .target_height (target_height),
        .skip_id       (skip_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_id     (result_id),
        .hit           (hit),
        .status        (status),
        .shown_count   (shown_count)
    );

endmodule

// ===== hw/rtl/lzst_checker.sv =====
`include "layer_z_order_stack_hit_test_defines.svh"

module lzst_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [lzst_pkg::ID_W-1:0]      result_id,
    input logic                           hit,
    input logic [lzst_pkg::STAT_W-1:0]    status,
    input logic [lzst_pkg::ID_W-1:0]      shown_count
);
    import lzst_pkg::*;

    // a hit always names a real layer
    `LZST_ASSERT_NOW(a_hit_has_id, out_valid && hit, result_id != '0 && status == ST_OK)
    // the stack never holds more than MAX_LAYERS entries
    `LZST_ASSERT_NOW(a_count_bound, out_valid, shown_count <= ID_W'(MAX_LAYERS))
    // an error result carries no id
    `LZST_ASSERT_NOW(a_err_no_id, out_valid && status != ST_OK, result_id == '0 && !hit)
    // a stalled result holds
    `LZST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_id))

endmodule

bind layer_z_order_stack_hit_test lzst_checker u_lzst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_id   (result_id),
    .hit         (hit),
    .status      (status),
    .shown_count (shown_count)
);

// ===== dv/layer_z_order_stack_hit_test_test.sv =====
`timescale 1ns / 100ps

module layer_z_order_stack_hit_test_test;
    import lzst_pkg::*;

    localparam int N_RANDOM   = 1030;
    localparam int CALM_FROM  = 950;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 250;
    localparam int DRAIN_AT   = 650;
    localparam int LIMIT      = 400000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   layer_id;
        logic [15:0]       coord_x;
        logic [15:0]       coord_y;
        logic [12:0]       win_width;
        logic [12:0]       win_height;
        logic [TH_W-1:0]   target_height;
        logic [ID_W-1:0]   skip_id;
    } layer_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   result_id;
        logic              hit;
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   shown_count;
    } layer_rsp_t;

    typedef struct packed {
        layer_cmd_t cmd;
        logic       typed;
        layer_rsp_t rsp;
    } directed_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [OP_W-1:0]           op;
    logic [ID_W-1:0]           layer_id;
    logic signed [15:0]        coord_x;
    logic signed [15:0]        coord_y;
    logic [12:0]               win_width;
    logic [12:0]               win_height;
    logic signed [TH_W-1:0]    target_height;
    logic [ID_W-1:0]           skip_id;
    logic                      out_valid;
    logic                      out_ready;
    logic [ID_W-1:0]           result_id;
    logic                      hit;
    logic [STAT_W-1:0]         status;
    logic [ID_W-1:0]           shown_count;

    // Shadow copy of the layer table and the bottom-to-top visibility stack.
    logic [ID_W-1:0]    shadow_stack [MAX_LAYERS];
    int                 shadow_count;
    int                 shadow_last;
    logic signed [15:0] shadow_x [MAX_LAYERS];
    logic signed [15:0] shadow_y [MAX_LAYERS];
    logic [12:0]        shadow_w [MAX_LAYERS];
    logic [12:0]        shadow_h [MAX_LAYERS];
    logic               shadow_win [MAX_LAYERS];

    layer_rsp_t pending_rsp [$];
    int         items_sent;
    bit         calm;
    bit         hold_req;
    bit         failed;
    bit         stim_done;
    int         cycle;

    layer_z_order_stack_hit_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .layer_id(layer_id), .coord_x(coord_x), .coord_y(coord_y),
        .win_width(win_width), .win_height(win_height),
        .target_height(target_height), .skip_id(skip_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_id(result_id), .hit(hit), .status(status),
        .shown_count(shown_count)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Drop out with a failure if the run never drains.
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Remove an id from the stack, closing the gap above it.
    function automatic void stack_pull(logic [ID_W-1:0] id);
        int pos;
        pos = -1;
        for (int i = 0; i < shadow_count; i++)
            if (pos < 0 && shadow_stack[i] == id)
                pos = i;
        if (pos < 0)
            return;
        for (int i = pos; i + 1 < shadow_count; i++)
            shadow_stack[i] = shadow_stack[i + 1];
        shadow_count--;
    endfunction

    // Apply one command to the shadow state and return the response it gives.
    function automatic layer_rsp_t layer_apply(layer_cmd_t c);
        layer_rsp_t r;
        bit         known;
        int         k;
        int         h;
        int         px, py, x0, y0;
        logic [ID_W-1:0] sid;
        r = '0;
        known = (c.layer_id >= 1) && (c.layer_id <= shadow_last);
        k = known ? c.layer_id - 1 : 0;
        case (c.op)
            OP_NEW:
            begin
                if (shadow_last < MAX_LAYERS)
                begin
                    shadow_x[shadow_last]   = '0;
                    shadow_y[shadow_last]   = '0;
                    shadow_w[shadow_last]   = '0;
                    shadow_h[shadow_last]   = '0;
                    shadow_win[shadow_last] = 1'b0;
                    shadow_last++;
                    r.result_id = ID_W'(shadow_last);
                end
                else
                    r.status = ST_NOFREE;
            end
            OP_FIND:
            begin
                px = $signed(c.coord_x);
                py = $signed(c.coord_y);
                // Walk top down; end bounds are inclusive and never wrap.
                for (int i = shadow_count - 1; i >= 0 && !r.hit; i--)
                begin
                    sid = shadow_stack[i];
                    if (sid != c.skip_id && shadow_win[sid - 1])
                    begin
                        x0 = shadow_x[sid - 1];
                        y0 = shadow_y[sid - 1];
                        if (x0 <= px && px <= x0 + int'(shadow_w[sid - 1]) &&
                            y0 <= py && py <= y0 + int'(shadow_h[sid - 1]))
                        begin
                            r.result_id = sid;
                            r.hit = 1'b1;
                        end
                    end
                end
            end
            OP_WINDOW, OP_MOVE, OP_MOVEREL, OP_RESTACK, OP_HIDE:
            begin
                if (!known)
                    r.status = ST_UNKNOWN;
                else if (c.op == OP_WINDOW)
                begin
                    shadow_w[k] = c.win_width;
                    shadow_h[k] = c.win_height;
                    shadow_win[k] = 1'b1;
                end
                else if (c.op == OP_MOVE)
                begin
                    shadow_x[k] = c.coord_x;
                    shadow_y[k] = c.coord_y;
                end
                else if (c.op == OP_MOVEREL)
                begin
                    shadow_x[k] = shadow_x[k] + $signed(c.coord_x);
                    shadow_y[k] = shadow_y[k] + $signed(c.coord_y);
                end
                else
                begin
                    stack_pull(c.layer_id);
                    h = $signed(c.target_height);
                    // Negative height hides; too large clamps to the top.
                    if (c.op == OP_RESTACK && h >= 0)
                    begin
                        if (h > shadow_count)
                            h = shadow_count;
                        for (int i = shadow_count; i > h; i--)
                            shadow_stack[i] = shadow_stack[i - 1];
                        shadow_stack[h] = c.layer_id;
                        shadow_count++;
                    end
                end
            end
            default: ;
        endcase
        r.shown_count = ID_W'(shadow_count);
        return r;
    endfunction

    function automatic layer_cmd_t mk(logic [OP_W-1:0] o, int id, int x, int y,
                                      int w, int h, int th, int ex);
        layer_cmd_t c;
        c.op = o;
        c.layer_id = ID_W'(id);
        c.coord_x = 16'(x);
        c.coord_y = 16'(y);
        c.win_width = 13'(w);
        c.win_height = 13'(h);
        c.target_height = TH_W'(th);
        c.skip_id = ID_W'(ex);
        return c;
    endfunction

    function automatic layer_rsp_t rs(int id, int ht, logic [STAT_W-1:0] st, int cnt);
        layer_rsp_t r;
        r.result_id = ID_W'(id);
        r.hit = 1'(ht);
        r.status = st;
        r.shown_count = ID_W'(cnt);
        return r;
    endfunction

    // Random command, biased toward known ids and points near existing layers.
    function automatic layer_cmd_t random_cmd();
        layer_cmd_t c;
        int sel;
        int k;
        int top;
        c = '0;
        c.coord_x = 16'($urandom);
        c.coord_y = 16'($urandom);
        c.skip_id = ($urandom_range(0, 1) == 0) ? ID_W'(0)
                                                : ID_W'($urandom_range(0, MAX_LAYERS));
        sel = $urandom_range(0, 99);
        if (sel < 7)       c.op = OP_NEW;
        else if (sel < 22) c.op = OP_WINDOW;
        else if (sel < 32) c.op = OP_MOVE;
        else if (sel < 42) c.op = OP_MOVEREL;
        else if (sel < 64) c.op = OP_RESTACK;
        else if (sel < 72) c.op = OP_HIDE;
        else               c.op = OP_FIND;
        top = (shadow_last > 0) ? shadow_last : 1;
        c.layer_id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, MAX_LAYERS))
                                                 : ID_W'($urandom_range(1, top));
        if ($urandom_range(0, 4) == 0)
        begin
            c.win_width = 13'($urandom);
            c.win_height = 13'($urandom);
        end
        else
        begin
            c.win_width = 13'($urandom_range(0, 300));
            c.win_height = 13'($urandom_range(0, 300));
        end
        sel = $urandom_range(0, 99);
        if (sel < 70)      c.target_height = TH_W'($urandom_range(0, MAX_LAYERS + 1));
        else if (sel < 85) c.target_height = TH_W'(-$urandom_range(1, 128));
        else               c.target_height = TH_W'($urandom);
        if (c.op == OP_MOVEREL && $urandom_range(0, 1) == 0)
        begin
            c.coord_x = 16'($signed($urandom_range(0, 400)) - 200);
            c.coord_y = 16'($signed($urandom_range(0, 400)) - 200);
        end
        if (c.op == OP_FIND && shadow_last > 0 && $urandom_range(0, 9) < 8)
        begin
            k = $urandom_range(0, shadow_last - 1);
            c.coord_x = 16'(shadow_x[k] + $signed($urandom_range(0, shadow_w[k] + 2)) - 1);
            c.coord_y = 16'(shadow_y[k] + $signed($urandom_range(0, shadow_h[k] + 2)) - 1);
        end
        return c;
    endfunction

    // Offer one command, hold it until the transfer, then book its response.
    task automatic offer(layer_cmd_t c, bit typed, layer_rsp_t typed_rsp);
        layer_rsp_t p;
        in_valid      <= 1'b1;
        op            <= c.op;
        layer_id      <= c.layer_id;
        coord_x       <= c.coord_x;
        coord_y       <= c.coord_y;
        win_width     <= c.win_width;
        win_height    <= c.win_height;
        target_height <= c.target_height;
        skip_id       <= c.skip_id;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = layer_apply(c);
        pending_rsp.push_back(typed ? typed_rsp : p);
        items_sent++;
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stimulus: reset, the directed table, then random traffic.
    initial
    begin
        directed_row_t rows [$];
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        layer_id = '0;
        coord_x = '0;
        coord_y = '0;
        win_width = '0;
        win_height = '0;
        target_height = '0;
        skip_id = '0;
        shadow_count = 0;
        shadow_last = 0;
        for (int i = 0; i < MAX_LAYERS; i++)
            shadow_win[i] = 1'b0;
        items_sent = 0;
        calm = 0;
        hold_req = 0;
        failed = 0;
        stim_done = 0;
        cycle = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows.push_back({mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_MOVE, 0, 5, 5, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_UNKNOWN, 0)});
        rows.push_back({mk(OP_HIDE, 1, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_UNKNOWN, 0)});
        rows.push_back({mk(OP_NEW, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(1, 0, ST_OK, 0)});
        rows.push_back({mk(OP_WINDOW, 2, 0, 0, 3, 3, 0, 0), 1'b1, rs(0, 0, ST_UNKNOWN, 0)});
        rows.push_back({mk(OP_RESTACK, 1, 0, 0, 0, 0, 127, 0), 1'b1, rs(0, 0, ST_OK, 1)});
        // Windowless layer is never hit.
        rows.push_back({mk(OP_FIND, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_WINDOW, 1, 0, 0, 8191, 8191, 0, 0), 1'b1, rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_MOVE, 1, -32768, -32768, 0, 0, 0, 0), 1'b1,
                        rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_FIND, 0, -32768, -32768, 0, 0, 0, 0), 1'b1,
                        rs(1, 1, ST_OK, 1)});
        rows.push_back({mk(OP_FIND, 0, -24577, -24577, 0, 0, 0, 0), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_FIND, 0, -24576, -32768, 0, 0, 0, 0), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_FIND, 0, -32768, -32768, 0, 0, 0, 1), 1'b1,
                        rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_MOVEREL, 1, -1, 32767, 0, 0, 0, 0), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_NEW, 0, 0, 0, 0, 0, 0, 0), 1'b1, rs(2, 0, ST_OK, 1)});
        rows.push_back({mk(OP_WINDOW, 2, 0, 0, 0, 0, 0, 0), 1'b0, rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_MOVE, 2, 32767, 32767, 0, 0, 0, 0), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_RESTACK, 2, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_OK, 2)});
        rows.push_back({mk(OP_FIND, 0, 32767, 32767, 0, 0, 0, 16), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_RESTACK, 1, 0, 0, 0, 0, 0, 0), 1'b0, rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_RESTACK, 2, 0, 0, 0, 0, 100, 0), 1'b0,
                        rs(0, 0, ST_OK, 0)});
        rows.push_back({mk(OP_RESTACK, 1, 0, 0, 0, 0, -128, 0), 1'b1,
                        rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_HIDE, 1, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_OK, 1)});
        rows.push_back({mk(OP_HIDE, 2, 0, 0, 0, 0, 0, 0), 1'b1, rs(0, 0, ST_OK, 0)});
        foreach (rows[i])
        begin
            sender_gap();
            offer(rows[i].cmd, rows[i].typed, rows[i].rsp);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == HOLD_AT)
                hold_req = 1;
            if (n == DRAIN_AT)
            begin
                // Pause the sender until every booked response has come back.
                in_valid <= 1'b0;
                while (pending_rsp.size() != 0)
                    @(posedge clk);
            end
            if (n == CALM_FROM)
                calm = 1;
            sender_gap();
            offer(random_cmd(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (2 * MAX_LAYERS + 20) @(posedge clk);
        if (!failed && pending_rsp.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: check each transfer against the oldest booked response, then
    // pick the next ready level, with one long hold-off to fill the block.
    initial
    begin
        layer_rsp_t want;
        int stall;
        int hold;
        out_ready = 1'b0;
        stall = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("response with nothing booked: id %0d", result_id);
                    failed = 1;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (result_id !== want.result_id)
                    begin
                        $error("result_id exp %0d got %0d", want.result_id, result_id);
                        failed = 1;
                    end
                    if (hit !== want.hit)
                    begin
                        $error("hit exp %0d got %0d", want.hit, hit);
                        failed = 1;
                    end
                    if (status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, status);
                        failed = 1;
                    end
                    if (shown_count !== want.shown_count)
                    begin
                        $error("shown_count exp %0d got %0d", want.shown_count,
                               shown_count);
                        failed = 1;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req = 0;
                hold = HOLD_LEN;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 7) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

endmodule
